// File: hw/rtl/blkd_pkg.sv
// ----------------------------------------------------------------------------
// blkd_pkg: shared types and constants for the bounded list deque
// Request and status codes, field widths and the per-cell command struct.
// ----------------------------------------------------------------------------
package blkd_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int REQ_W = 3;
    localparam int VAL_W = 32;
    localparam int POS_W = 4;
    localparam int ST_W  = 2;
    localparam int LEN_W = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_BACK   = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_REMOVE_AT  = 3'd4
    } t_req;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // broadcast to every cell for one request
    typedef struct packed {
        logic load_back;   // cell at target index loads the new value
        logic push_front;  // cell 0 loads, all others take from the left
        logic remove;      // cells at or above target take from the right
    } t_cell_cmd;

endpackage

// File: hw/rtl/blkd_req_if.sv
// ----------------------------------------------------------------------------
// blkd_req_if: request channel
// Valid/ready channel carrying one deque request.
// ----------------------------------------------------------------------------
interface blkd_req_if
    import blkd_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic        [REQ_W-1:0] req_type;
    logic signed [VAL_W-1:0] push_value;
    logic        [POS_W-1:0] position;

    modport source (output valid, output req_type, output push_value, output position,
                    input ready);
    modport sink   (input valid, input req_type, input push_value, input position,
                    output ready);
endinterface

// File: hw/rtl/blkd_rsp_if.sv
// ----------------------------------------------------------------------------
// blkd_rsp_if: response channel
// Valid/ready channel carrying one deque response.
// ----------------------------------------------------------------------------
interface blkd_rsp_if
    import blkd_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] taken_value;
    logic         [ST_W-1:0] status;
    logic        [LEN_W-1:0] length;

    modport source (output valid, output taken_value, output status, output length,
                    input ready);
    modport sink   (input valid, input taken_value, input status, input length,
                    output ready);
endinterface

// File: hw/rtl/bounded_list_deque_top.sv
// ----------------------------------------------------------------------------
// bounded_list_deque_top: bounded deque with indexed removal
// Row of DEPTH storage cells that shift toward either neighbor, plus a
// controller that keeps the fill count and registers each response.
//
//   channel  dir  handshake      payload
//   i_req    in   valid/ready    req_type, push_value, position
//   o_rsp    out  valid/ready    taken_value, status, length
//
// One request per cycle while o_rsp is not stalled: every cell loads, shifts
// or holds in the same cycle the request transfers; the response appears in
// the next cycle. The response register frees in the cycle it is taken, so a
// stalled o_rsp stalls i_req and nothing else.
// Reset clears the fill count and the response valid; entries are not cleared.
// ----------------------------------------------------------------------------
module bounded_list_deque_top
    import blkd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    blkd_req_if.sink    i_req,
    blkd_rsp_if.source  o_rsp
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cell_cmd        w_cmd;
    logic [IW-1:0]    w_tgt;
    logic [VAL_W-1:0] w_data  [DEPTH];
    logic [VAL_W-1:0] w_tap   [DEPTH];
    logic [VAL_W-1:0] w_left  [DEPTH];
    logic [VAL_W-1:0] w_right [DEPTH];
    logic [VAL_W-1:0] w_taken;

    blkd_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_tap   (w_taken),
        .o_cmd   (w_cmd),
        .o_tgt   (w_tgt)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = '0;
        end else begin : g_mid_l
            assign w_left[g] = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right[g] = w_data[g];
        end else begin : g_mid_r
            assign w_right[g] = w_data[g+1];
        end

        blkd_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_tgt   (w_tgt),
            .i_value (i_req.push_value),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_data  (w_data[g]),
            .o_tap   (w_tap[g])
        );
    end

    // only the targeted cell drives a nonzero tap
    always_comb begin
        w_taken = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_taken = w_taken | w_tap[k];
        end
    end

endmodule

// File: hw/rtl/blkd_cell.sv
// ----------------------------------------------------------------------------
// blkd_cell: one storage slot of the deque
// Holds one entry; loads, shifts from a neighbor or holds per the broadcast.
// ----------------------------------------------------------------------------
module blkd_cell
    import blkd_pkg::*;
#(
    parameter int IW  = 4,
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  t_cell_cmd         i_cmd,
    input  logic [IW-1:0]     i_tgt,
    input  logic [VAL_W-1:0]  i_value,
    input  logic [VAL_W-1:0]  i_left,
    input  logic [VAL_W-1:0]  i_right,
    output logic [VAL_W-1:0]  o_data,
    output logic [VAL_W-1:0]  o_tap
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [VAL_W-1:0] r_data;
    logic [VAL_W-1:0] n_data;
    logic             w_hit;

    assign w_hit = (i_tgt == MY_IDX);

    always_comb begin
        n_data = r_data;
        if (i_cmd.load_back && w_hit) begin
            n_data = i_value;
        end else if (i_cmd.push_front) begin
            n_data = (IDX == 0) ? i_value : i_left;
        end else if (i_cmd.remove && (MY_IDX >= i_tgt)) begin
            // entries past the end may take junk; they are never read
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = w_hit ? r_data : '0;

endmodule

// File: hw/rtl/blkd_ctrl.sv
// ----------------------------------------------------------------------------
// blkd_ctrl: request decode, fill count and response register
// Decodes a request into a cell command and registers the response.
// ----------------------------------------------------------------------------
module blkd_ctrl
    import blkd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    blkd_req_if.sink          i_req,
    blkd_rsp_if.source        o_rsp,
    input  logic [VAL_W-1:0]  i_tap,
    output t_cell_cmd         o_cmd,
    output logic [IW-1:0]     o_tgt
);

    localparam int            CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic             r_out_valid;
    logic [VAL_W-1:0] r_taken;
    t_status          r_status;
    logic [LEN_W-1:0] r_length;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    t_cell_cmd        w_cmd;
    t_status          w_status;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_cnt == CNT_FULL);
    assign w_empty     = (r_cnt == '0);

    always_comb begin
        w_cmd    = '0;
        o_tgt    = '0;
        w_status = ST_OK;
        n_cnt    = r_cnt;
        case (t_req'(i_req.req_type))
            REQ_PUSH_BACK: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.load_back = 1'b1;
                    o_tgt           = IW'(r_cnt);
                    n_cnt           = r_cnt + 1'b1;
                end
            end
            REQ_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.push_front = 1'b1;
                    n_cnt            = r_cnt + 1'b1;
                end
            end
            REQ_POP_BACK: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_cmd.remove = 1'b1;
                    o_tgt        = IW'(r_cnt - 1'b1);
                    n_cnt        = r_cnt - 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_cmd.remove = 1'b1;
                    n_cnt        = r_cnt - 1'b1;
                end
            end
            REQ_REMOVE_AT: begin
                if (CMPW'(i_req.position) >= CMPW'(r_cnt)) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_cmd.remove = 1'b1;
                    o_tgt        = IW'(i_req.position);
                    n_cnt        = r_cnt - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // cells only move on a transfer
    assign o_cmd = w_accept ? w_cmd : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_cnt <= n_cnt;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_taken  <= w_cmd.remove ? i_tap : '0;
            r_status <= w_status;
            r_length <= LEN_W'({{LEN_W{1'b0}}, n_cnt});
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.taken_value = r_taken;
    assign o_rsp.status      = r_status;
    assign o_rsp.length      = r_length;

endmodule

// File: hw/rtl/blkd_chk.sv
// ----------------------------------------------------------------------------
// blkd_chk: port-level checks for the bounded list deque
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module blkd_chk
    import blkd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input logic [VAL_W-1:0] i_rsp_taken,
    input logic [ST_W-1:0]  i_rsp_status,
    input logic [LEN_W-1:0] i_rsp_length
);

    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(DEPTH);

    // every request transfer yields a response next cycle
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> i_rsp_valid)
        else $error("no response after request transfer");

    // a held response blocks new requests
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |-> !i_req_ready)
        else $error("request taken while response stalled");

    // a failed request removes nothing
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != ST_OK)) |-> (i_rsp_taken == '0))
        else $error("nonzero value on failed request");

    // a dropped push only happens at full length
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status == ST_FULL)) |-> (i_rsp_length == LEN_FULL))
        else $error("full status with wrong length");

endmodule

bind bounded_list_deque_top blkd_chk #(
    .DEPTH (DEPTH)
) u_blkd_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_taken  (o_rsp.taken_value),
    .i_rsp_status (o_rsp.status),
    .i_rsp_length (o_rsp.length)
);
